// ===== rtl/assert_macros.svh =====
// Assertion macros used by the path attribute parser result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/bgpa_pkg.sv =====
// Types, codes and constants of the path attribute parser.
`timescale 1ns / 1ps

package bgpa_pkg;

  localparam int unsigned DEF_PATH_CAPACITY = 64;
  localparam int unsigned DEF_LIST_CAPACITY = 32;
  localparam int unsigned OUTQ_DEPTH        = 4;

  localparam logic [7:0] ATTR_ORIGIN        = 8'd1;
  localparam logic [7:0] ATTR_AS_PATH       = 8'd2;
  localparam logic [7:0] ATTR_NH            = 8'd3;
  localparam logic [7:0] ATTR_MED           = 8'd4;
  localparam logic [7:0] ATTR_LOCAL_PREF    = 8'd5;
  localparam logic [7:0] ATTR_COMMUNITIES   = 8'd8;
  localparam logic [7:0] ATTR_ORIGINATOR_ID = 8'd9;
  localparam logic [7:0] ATTR_CLUSTER_LIST  = 8'd10;
  localparam logic [7:0] ATTR_EXT_COMM      = 8'd16;
  localparam logic [7:0] ATTR_AS4_PATH      = 8'd17;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_ELEM    = 2'd1,
    KIND_END_OK  = 2'd2,
    KIND_END_ERR = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    PH_FLAGS  = 5'b00001,
    PH_CODE   = 5'b00010,
    PH_LEN_HI = 5'b00100,
    PH_LEN_LO = 5'b01000,
    PH_VALUE  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    SEG_HDR   = 3'b001,
    SEG_COUNT = 3'b010,
    SEG_BODY  = 3'b100
  } seg_e;

  typedef struct packed {
    phase_e      phase;
    logic        ext;
    logic [7:0]  code;
    logic [15:0] rem;
    logic [63:0] acc;
    logic [3:0]  cnt;
    logic [6:0]  ctr;
    logic [7:0]  segrem;
    seg_e        seg;
    logic        err;
  } pstate_t;

  localparam pstate_t STATE_RESET = '{
    phase:  PH_FLAGS,
    ext:    1'b0,
    code:   8'd0,
    rem:    16'd0,
    acc:    64'd0,
    cnt:    4'd0,
    ctr:    7'd0,
    segrem: 8'd0,
    seg:    SEG_HDR,
    err:    1'b0
  };

  // Fields run from the value at the top down to the kind in the lowest bits.
  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  idx;
    logic [15:0] length;
    logic [7:0]  code;
    kind_e       kind;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } entry_t;

endpackage

// ===== rtl/bgpa_step.sv =====
// Next-state and result logic for one byte of the attribute block.
`timescale 1ns / 1ps

module bgpa_step import bgpa_pkg::*; #(
  parameter int unsigned PATH_CAPACITY = DEF_PATH_CAPACITY,
  parameter int unsigned LIST_CAPACITY = DEF_LIST_CAPACITY
) (
  input  pstate_t    state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pstate_t    state_o,
  output logic       elem_vld_o,
  output result_t    elem_o,
  output result_t    end_o
);

  localparam logic [6:0] PathCap = 7'(PATH_CAPACITY);
  localparam logic [6:0] ListCap = 7'(LIST_CAPACITY);

  function automatic logic [3:0] item_size(input logic [7:0] code);
    logic [3:0] sz;
    sz = 4'd0;
    if (code == ATTR_ORIGIN) begin
      sz = 4'd1;
    end else if (code inside {ATTR_NH, ATTR_MED, ATTR_LOCAL_PREF,
                              ATTR_ORIGINATOR_ID, ATTR_COMMUNITIES,
                              ATTR_CLUSTER_LIST}) begin
      sz = 4'd4;
    end else if (code == ATTR_EXT_COMM) begin
      sz = 4'd8;
    end
    return sz;
  endfunction

  logic        is_path;
  logic        is_list;
  logic [3:0]  asz;
  logic [3:0]  gsz;
  logic [6:0]  cap;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic [63:0] acc_sh;
  logic [3:0]  cnt_inc;
  logic        bad;
  logic        known;
  seg_e        sp;
  pstate_t     nx;

  assign is_path = (state_i.code == ATTR_AS_PATH) || (state_i.code == ATTR_AS4_PATH);
  assign is_list = state_i.code inside {ATTR_COMMUNITIES, ATTR_CLUSTER_LIST, ATTR_EXT_COMM};
  assign asz     = (state_i.code == ATTR_AS_PATH) ? 4'd2 : 4'd4;
  assign gsz     = item_size(state_i.code);
  assign cap     = is_list ? ListCap : 7'd1;
  assign len     = {state_i.rem[15:8], byte_i};
  assign rem_dec = state_i.rem - 16'd1;
  assign acc_sh  = {state_i.acc[55:0], byte_i};
  assign cnt_inc = state_i.cnt + 4'd1;
  assign known   = (gsz != 4'd0) || is_path;
  assign bad     = ((state_i.code == ATTR_ORIGIN) && (len != 16'd1)) ||
                   ((state_i.code inside {ATTR_NH, ATTR_MED, ATTR_LOCAL_PREF,
                                          ATTR_ORIGINATOR_ID}) && (len != 16'd4));

  always_comb begin
    nx         = state_i;
    sp         = state_i.seg;
    elem_vld_o = 1'b0;
    elem_o     = '{value: 64'd0, idx: 6'd0, length: 16'd0,
                   code: state_i.code, kind: KIND_START};
    end_o      = '{value: 64'd0, idx: 6'd0, length: 16'd0,
                   code: 8'd0, kind: KIND_END_OK};

    if (!state_i.err) begin
      case (state_i.phase)
        PH_FLAGS: begin
          nx.ext   = byte_i[4];
          nx.phase = PH_CODE;
        end
        PH_CODE: begin
          nx.code  = byte_i;
          nx.phase = state_i.ext ? PH_LEN_HI : PH_LEN_LO;
        end
        PH_LEN_HI: begin
          nx.rem   = {byte_i, 8'h00};
          nx.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          nx.rem = len;
          if (bad) begin
            nx.err = 1'b1;
          end else begin
            if (known) begin
              elem_vld_o    = 1'b1;
              elem_o.length = len;
            end
            nx.acc    = 64'd0;
            nx.cnt    = 4'd0;
            nx.ctr    = 7'd0;
            nx.segrem = 8'd0;
            nx.seg    = SEG_HDR;
            nx.phase  = (len == 16'd0) ? PH_FLAGS : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (is_path) begin
            // An ASN that cannot finish inside the segment or the attribute
            // turns this byte into the start of a new segment header.
            if (state_i.seg == SEG_BODY && state_i.cnt == 4'd0 &&
                (state_i.segrem == 8'd0 || state_i.rem < {12'd0, asz})) begin
              sp = SEG_HDR;
            end
            case (sp)
              SEG_HDR: begin
                nx.seg = SEG_COUNT;
              end
              SEG_COUNT: begin
                nx.segrem = byte_i;
                nx.seg    = SEG_BODY;
              end
              default: begin
                nx.acc = acc_sh;
                nx.cnt = cnt_inc;
                if (cnt_inc >= asz) begin
                  nx.cnt = 4'd0;
                  nx.acc = 64'd0;
                  if (state_i.segrem != 8'd0) begin
                    nx.segrem = state_i.segrem - 8'd1;
                  end
                  if (state_i.ctr < PathCap) begin
                    elem_vld_o   = 1'b1;
                    elem_o.kind  = KIND_ELEM;
                    elem_o.idx   = state_i.ctr[5:0];
                    elem_o.value = acc_sh;
                    nx.ctr       = state_i.ctr + 7'd1;
                  end
                end
              end
            endcase
          end else if (gsz != 4'd0 &&
                       !(state_i.cnt == 4'd0 && state_i.rem < {12'd0, gsz})) begin
            nx.acc = acc_sh;
            nx.cnt = cnt_inc;
            if (cnt_inc >= gsz) begin
              nx.cnt = 4'd0;
              nx.acc = 64'd0;
              if (state_i.ctr < cap) begin
                elem_vld_o   = 1'b1;
                elem_o.kind  = KIND_ELEM;
                elem_o.idx   = state_i.ctr[5:0];
                elem_o.value = acc_sh;
                nx.ctr       = state_i.ctr + 7'd1;
              end
            end
          end
          nx.rem = rem_dec;
          if (rem_dec == 16'd0) begin
            nx.phase  = PH_FLAGS;
            nx.acc    = 64'd0;
            nx.cnt    = 4'd0;
            nx.ctr    = 7'd0;
            nx.segrem = 8'd0;
            nx.seg    = SEG_HDR;
          end
        end
        default: begin
          nx = STATE_RESET;
        end
      endcase
    end

    if (last_i) begin
      end_o.kind = (nx.err || nx.phase != PH_FLAGS) ? KIND_END_ERR : KIND_END_OK;
      nx         = STATE_RESET;
    end
  end

  assign state_o = nx;

endmodule

// ===== rtl/bgpa_outq.sv =====
// Small result queue that takes up to two beats per cycle while it has room and hands out one when the reader is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bgpa_outq import bgpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  entry_t     push0_i,
  input  entry_t     push1_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output entry_t     out_data_o
);

  localparam int unsigned PtrW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CntW = $clog2(OUTQ_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(OUTQ_DEPTH - 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  entry_t          mem_q [OUTQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr_nx;
  logic            pop;

  assign wr_ptr_nx   = ptr_inc(wr_ptr_q);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room for a full pair of beats is kept so a last byte never stalls mid-write.
  assign in_ready_o  = (count_q <= CntW'(OUTQ_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_n_i == 2'd1) begin
      wr_ptr_d = wr_ptr_nx;
    end else if (push_n_i == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(OUTQ_DEPTH))
  `ASSERT_AT(a_no_push_unready, clk_i, rst_ni, !in_ready_o |-> push_n_i == 2'd0)
  `ASSERT_AT(a_count_hold, clk_i, rst_ni, (push_n_i == 2'd0 && !pop) |=> $stable(count_q))

endmodule

// ===== rtl/bgp_path_attribute_parser.sv =====
// Path attribute parser top level: one byte per cycle, results are queued in registers.
// Throughput is one byte per cycle while fewer than three result beats wait in the queue.
// A last byte that also completes an element gives two result beats in a row.
// Reset (rst_ni low, asynchronous) clears the parse state and empties the result queue.
`timescale 1ns / 1ps

module bgp_path_attribute_parser import bgpa_pkg::*; #(
  parameter int unsigned PATH_CAPACITY = DEF_PATH_CAPACITY,
  parameter int unsigned LIST_CAPACITY = DEF_LIST_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // attr_code[7:0], attr_length[23:8], elem_index[29:24], elem_value[93:30],
  // zero[95:94]
  output logic [95:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  pstate_t    state_q, state_d;
  logic       elem_vld;
  result_t    elem_res;
  result_t    end_res;
  logic       s_accept;
  logic [1:0] push_n;
  entry_t     push0;
  entry_t     push1;
  entry_t     out_entry;

  bgpa_step #(
    .PATH_CAPACITY (PATH_CAPACITY),
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_step (
    .state_i    (state_q),
    .byte_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .state_o    (state_d),
    .elem_vld_o (elem_vld),
    .elem_o     (elem_res),
    .end_o      (end_res)
  );

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    push_n = 2'd0;
    if (s_accept) begin
      push_n = {1'b0, elem_vld} + {1'b0, s_axis_tlast_i};
    end
    push1 = '{res: end_res, last: 1'b1};
    if (elem_vld) begin
      push0 = '{res: elem_res, last: !s_axis_tlast_i};
    end else begin
      push0 = push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (s_accept) begin
      state_q <= state_d;
    end
  end

  bgpa_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (push0),
    .push1_i     (push1),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_entry)
  );

  assign m_axis_tdata_o = {2'b00, out_entry.res.value, out_entry.res.idx,
                           out_entry.res.length, out_entry.res.code};
  assign m_axis_tuser_o = out_entry.res.kind;
  assign m_axis_tlast_o = out_entry.last;

endmodule
